### rtl/core/srls_pkg.sv
`default_nettype none

package srls_pkg;

  // Datapath widths
  localparam int SUM_W   = 42;  // square sum, mean, square-root remainder
  localparam int UW      = 44;  // shared adder/subtractor
  localparam int DVS_W   = 16;  // divisor and partial remainder
  localparam int MAG_W   = 28;  // magnitude of the radius numerator
  localparam int MUL_W   = 18;  // multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CNT_W   = 6;   // iteration counter

  localparam int DIV_MEAN_STEPS = SUM_W;
  localparam int DIV_MAP_STEPS  = MAG_W;
  localparam int SQRT_STEPS     = SUM_W / 2;
  localparam int SQRT_BIT0      = SUM_W - 2;

  localparam logic [14:0] LEVEL_MAX  = 15'd16384;
  localparam logic [11:0] RADIUS_MAX = 12'd4095;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_INPUT_SPAN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH      = 3'd4;

  localparam logic [15:0] RST_SMOOTHING_WEIGHT = 16'd4588;
  localparam logic [14:0] RST_LEVEL_THRESHOLD  = 15'd1638;
  localparam logic [14:0] RST_MAP_INPUT_SPAN   = 15'd3277;
  localparam logic [11:0] RST_OUTPUT_LOW       = 12'd200;
  localparam logic [11:0] RST_OUTPUT_HIGH      = 12'd500;

  typedef struct packed {
    logic [15:0] smoothing_weight;
    logic [14:0] level_threshold;
    logic [14:0] map_input_span;
    logic [11:0] output_low;
    logic [11:0] output_high;
  } cfg_t;

  typedef struct packed {
    logic [14:0] rms_level;
    logic [14:0] smoothed_level;
    logic [11:0] radius;
  } result_t;

  // Operation of the shared adder: res = a + (inv ? ~b : b) + cin
  typedef struct packed {
    logic inv;
    logic cin;
  } uop_t;

endpackage

`default_nettype wire

### rtl/core/srls_addsub.sv
`default_nettype none

module srls_addsub (
  input  wire logic [srls_pkg::UW-1:0] a,
  input  wire logic [srls_pkg::UW-1:0] b,
  input  wire srls_pkg::uop_t          op,
  output logic      [srls_pkg::UW-1:0] res,
  output logic                         cout
);

  logic [srls_pkg::UW-1:0] b_eff;

  assign b_eff = op.inv ? ~b : b;
  // Carry out of a subtract means a >= b (unsigned)
  assign {cout, res} = {1'b0, a} + {1'b0, b_eff} + {{srls_pkg::UW{1'b0}}, op.cin};

endmodule

`default_nettype wire

### rtl/core/srls_seq.sv
`default_nettype none

module srls_seq #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire srls_pkg::cfg_t         cfg,
  input  wire logic                   in_take,
  input  wire logic signed [15:0]     left_sample,
  input  wire logic signed [15:0]     right_sample,
  input  wire logic                   last_frame,
  output logic                        busy,
  output logic                        res_valid,
  input  wire logic                   slot_free,
  output srls_pkg::result_t           res
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);
  localparam int UW = srls_pkg::UW;
  localparam int SW = srls_pkg::SUM_W;
  localparam int DW = srls_pkg::DVS_W;
  localparam int MW = srls_pkg::MUL_W;
  localparam int PW = srls_pkg::PROD_W;
  localparam int NW = srls_pkg::MAG_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_SQL  = 15'h0002,
    S_SQR  = 15'h0004,
    S_ADD  = 15'h0008,
    S_DIV  = 15'h0010,
    S_SQRT = 15'h0020,
    S_SM1  = 15'h0040,
    S_SM2  = 15'h0080,
    S_SM3  = 15'h0100,
    S_SM4  = 15'h0200,
    S_MP1  = 15'h0400,
    S_MP2  = 15'h0800,
    S_MP3  = 15'h1000,
    S_MP4  = 15'h2000,
    S_OUT  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0]  l_r, r_r;
  logic                last_r;
  logic [SW-1:0]       sum_r;
  logic [CW-1:0]       count_r;
  logic signed [PW-1:0] prod_r;
  logic [UW-1:0]       acc_r;
  logic [SW-1:0]       dvd_r;
  logic [DW-1:0]       rem_r, dvs_r;
  logic [srls_pkg::CNT_W-1:0] cnt_r;
  logic                mode_map_r;
  logic [SW-1:0]       root_r, bit_r;
  logic [14:0]         rms_r, smooth_r;
  logic                neg_r;
  logic [11:0]         rad_r;

  logic                room;
  logic [CW-1:0]       count_inc;
  logic [16:0]         w_comp;
  logic signed [12:0]  span_diff;
  logic [14:0]         span_eff;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] mul;
  logic [UW-1:0]       ua, ub, ures;
  srls_pkg::uop_t      uop;
  logic                ucout;
  logic [14:0]         sm_clamp;
  logic [UW-1:0]       mag;
  logic [11:0]         rad_sat;

  assign room      = count_r < MAX_CNT;
  assign count_inc = count_r + CW'(1);
  assign w_comp    = 17'h10000 - {1'b0, cfg.smoothing_weight};
  assign span_diff = $signed({1'b0, cfg.output_high}) - $signed({1'b0, cfg.output_low});
  assign span_eff  = (cfg.map_input_span == 15'd0) ? 15'd1 : cfg.map_input_span;

  // Shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_SQL: begin
        ma = {{2{l_r[15]}}, l_r};
        mb = {{2{l_r[15]}}, l_r};
      end
      S_SQR: begin
        ma = {{2{r_r[15]}}, r_r};
        mb = {{2{r_r[15]}}, r_r};
      end
      S_SM1: begin
        ma = {3'b0, smooth_r};
        mb = {1'b0, w_comp};
      end
      S_SM2: begin
        ma = {3'b0, rms_r};
        mb = {2'b0, cfg.smoothing_weight};
      end
      S_MP1: begin
        ma = {{5{span_diff[12]}}, span_diff};
        mb = {3'b0, smooth_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul = ma * mb;

  // Shared adder operands
  always_comb begin
    ua  = '0;
    ub  = '0;
    uop = '{inv: 1'b0, cin: 1'b0};
    unique case (state_r)
      S_SQR, S_ADD: begin
        ua = {2'b0, sum_r};
        ub = {10'b0, prod_r[PW-1:2]};
      end
      S_DIV: begin
        ua  = {27'b0, rem_r, dvd_r[SW-1]};
        ub  = {28'b0, dvs_r};
        uop = '{inv: 1'b1, cin: 1'b1};
      end
      S_SQRT: begin
        ua  = {2'b0, dvd_r};
        ub  = {2'b0, root_r | bit_r};
        uop = '{inv: 1'b1, cin: 1'b1};
      end
      S_SM2: begin
        ua = {{8{prod_r[PW-1]}}, prod_r};
        ub = 44'd32768;
      end
      S_SM3: begin
        ua = acc_r;
        ub = {{8{prod_r[PW-1]}}, prod_r};
      end
      S_MP2: begin
        ua = {{7{prod_r[PW-1]}}, prod_r, 1'b0};
        ub = {29'b0, span_eff};
      end
      S_MP3: begin
        ua  = '0;
        ub  = acc_r;
        uop = '{inv: 1'b1, cin: 1'b1};
      end
      S_MP4: begin
        // negative numerator: lo - (q + (rem != 0))
        ua  = {32'b0, cfg.output_low};
        ub  = {16'b0, dvd_r[NW-1:0]};
        uop = '{inv: neg_r, cin: neg_r & (rem_r == '0)};
      end
      default: begin
        ua  = '0;
        ub  = '0;
        uop = '{inv: 1'b0, cin: 1'b0};
      end
    endcase
  end

  srls_addsub u_addsub (
    .a    (ua),
    .b    (ub),
    .op   (uop),
    .res  (ures),
    .cout (ucout)
  );

  assign sm_clamp = (acc_r[UW-1:16] > 28'd16384) ? srls_pkg::LEVEL_MAX : acc_r[30:16];
  assign mag      = acc_r[UW-1] ? ures : acc_r;

  always_comb begin
    if (ures[UW-1]) begin
      rad_sat = 12'd0;
    end else if (ures[UW-2:12] != '0) begin
      rad_sat = srls_pkg::RADIUS_MAX;
    end else begin
      rad_sat = ures[11:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_take) state_nxt = S_SQL;
      S_SQL:  state_nxt = S_SQR;
      S_SQR:  state_nxt = S_ADD;
      S_ADD:  state_nxt = last_r ? S_DIV : S_IDLE;
      S_DIV: begin
        if (cnt_r == srls_pkg::CNT_W'(1)) state_nxt = mode_map_r ? S_MP4 : S_SQRT;
      end
      S_SQRT: if (cnt_r == srls_pkg::CNT_W'(1)) state_nxt = S_SM1;
      S_SM1:  state_nxt = S_SM2;
      S_SM2:  state_nxt = S_SM3;
      S_SM3:  state_nxt = S_SM4;
      S_SM4:  state_nxt = (sm_clamp > cfg.level_threshold) ? S_MP1 : S_OUT;
      S_MP1:  state_nxt = S_MP2;
      S_MP2:  state_nxt = S_MP3;
      S_MP3:  state_nxt = S_DIV;
      S_MP4:  state_nxt = S_OUT;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sum_r    <= '0;
      count_r  <= '0;
      smooth_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            l_r    <= left_sample;
            r_r    <= right_sample;
            last_r <= last_frame;
          end
        end
        S_SQL: prod_r <= mul;
        S_SQR: begin
          if (room) sum_r <= ures[SW-1:0];
          prod_r <= mul;
        end
        S_ADD: begin
          if (last_r) begin
            // hand the buffer to the divider and start a fresh one
            dvd_r      <= room ? ures[SW-1:0] : sum_r;
            dvs_r      <= room ? DW'({count_inc, 1'b0}) : DW'({count_r, 1'b0});
            rem_r      <= '0;
            cnt_r      <= srls_pkg::CNT_W'(srls_pkg::DIV_MEAN_STEPS);
            mode_map_r <= 1'b0;
            sum_r      <= '0;
            count_r    <= '0;
          end else if (room) begin
            sum_r   <= ures[SW-1:0];
            count_r <= count_inc;
          end
        end
        S_DIV: begin
          rem_r <= ucout ? ures[DW-1:0] : {rem_r[DW-2:0], dvd_r[SW-1]};
          dvd_r <= {dvd_r[SW-2:0], ucout};
          if (cnt_r == srls_pkg::CNT_W'(1) && !mode_map_r) begin
            root_r <= '0;
            bit_r  <= SW'(1) << srls_pkg::SQRT_BIT0;
            cnt_r  <= srls_pkg::CNT_W'(srls_pkg::SQRT_STEPS);
          end else begin
            cnt_r <= cnt_r - srls_pkg::CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (ucout) begin
            dvd_r  <= ures[SW-1:0];
            root_r <= (root_r >> 1) | bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - srls_pkg::CNT_W'(1);
        end
        S_SM1: begin
          rms_r  <= (root_r > SW'(srls_pkg::LEVEL_MAX)) ? srls_pkg::LEVEL_MAX : root_r[14:0];
          prod_r <= mul;
        end
        S_SM2: begin
          acc_r  <= ures;
          prod_r <= mul;
        end
        S_SM3: acc_r <= ures;
        S_SM4: begin
          smooth_r <= sm_clamp;
          rad_r    <= cfg.output_low;
        end
        S_MP1: prod_r <= mul;
        S_MP2: acc_r <= ures;
        S_MP3: begin
          neg_r      <= acc_r[UW-1];
          dvd_r      <= {mag[NW-1:0], {(SW - NW){1'b0}}};
          dvs_r      <= {span_eff, 1'b0};
          rem_r      <= '0;
          cnt_r      <= srls_pkg::CNT_W'(srls_pkg::DIV_MAP_STEPS);
          mode_map_r <= 1'b1;
        end
        S_MP4: rad_r <= rad_sat;
        S_OUT: ;
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res.rms_level      = rms_r;
  assign res.smoothed_level = smooth_r;
  assign res.radius         = rad_r;

endmodule

`default_nettype wire

### rtl/core/stereo_rms_level_smoother.sv
`default_nettype none

// Stereo RMS level meter with exponential smoothing and a radius map.
// Input channel: one stereo frame per transaction (in_valid / in_stall).
// in_last_frame closes a buffer; only that frame produces a result
// transaction on the output channel (out_valid / out_stall).
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// indexes beyond the register list are ignored. Write only while idle.
// Processing: a frame that does not close a buffer is summed before the next
// accept (squares go one at a time through the multiplier).
// A last frame then runs a 42-step restoring division, a 21-step square
// root and, when the map applies (smoothed level above the threshold), a
// 28-step division, all on one shared adder/subtractor.
// The result reaches out_valid in the same cycle that in_stall drops.
// in_stall stays high while a frame is being worked on. When the receiver
// stalls, the result holds in the output register; the next buffer's frames
// are still taken and only a further result waits for the register to free.
// Reset (rst_n low at a clock edge) restores the register defaults, clears
// the square sum, frame count and smoothed level, and drops out_valid.
module stereo_rms_level_smoother #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [15:0]                   in_left_sample,
  input  wire logic signed [15:0]                   in_right_sample,
  input  wire logic                                 in_last_frame,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [14:0]                               out_rms_level,
  output logic [14:0]                               out_smoothed_level,
  output logic [11:0]                               out_radius,
  input  wire logic                                 cfg_we,
  input  wire logic [srls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [15:0]                          cfg_wdata
);

  srls_pkg::cfg_t    cfg_r;
  srls_pkg::result_t res;
  srls_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              busy;
  logic              res_valid;
  logic              slot_free;
  logic              in_take;

  assign in_take   = in_valid && !busy;
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_weight <= srls_pkg::RST_SMOOTHING_WEIGHT;
      cfg_r.level_threshold  <= srls_pkg::RST_LEVEL_THRESHOLD;
      cfg_r.map_input_span   <= srls_pkg::RST_MAP_INPUT_SPAN;
      cfg_r.output_low       <= srls_pkg::RST_OUTPUT_LOW;
      cfg_r.output_high      <= srls_pkg::RST_OUTPUT_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srls_pkg::REG_SMOOTHING_WEIGHT: cfg_r.smoothing_weight <= cfg_wdata;
        srls_pkg::REG_LEVEL_THRESHOLD:  cfg_r.level_threshold  <= cfg_wdata[14:0];
        srls_pkg::REG_MAP_INPUT_SPAN:   cfg_r.map_input_span   <= cfg_wdata[14:0];
        srls_pkg::REG_OUTPUT_LOW:       cfg_r.output_low       <= cfg_wdata[11:0];
        srls_pkg::REG_OUTPUT_HIGH:      cfg_r.output_high      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  srls_seq #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_take      (in_take),
    .left_sample  (in_left_sample),
    .right_sample (in_right_sample),
    .last_frame   (in_last_frame),
    .busy         (busy),
    .res_valid    (res_valid),
    .slot_free    (slot_free),
    .res          (res)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_res_r <= res;
    end
  end

  assign in_stall           = busy;
  assign out_valid          = out_valid_r;
  assign out_rms_level      = out_res_r.rms_level;
  assign out_smoothed_level = out_res_r.smoothed_level;
  assign out_radius         = out_res_r.radius;

endmodule

`default_nettype wire

### dv/tb_stereo_rms_level_smoother.sv
`timescale 1ns / 100ps

class level_meter_scoreboard #(int MAX_FRAMES = 256);
  srls_pkg::cfg_t    regs;
  logic [41:0]       square_sum;
  int unsigned       frames;
  logic [15:0]       smoothed;
  srls_pkg::result_t level_q[$];
  int                errors;

  function new();
    regs = '{srls_pkg::RST_SMOOTHING_WEIGHT, srls_pkg::RST_LEVEL_THRESHOLD,
             srls_pkg::RST_MAP_INPUT_SPAN, srls_pkg::RST_OUTPUT_LOW,
             srls_pkg::RST_OUTPUT_HIGH};
    square_sum = '0;
    frames = 0;
    smoothed = '0;
    errors = 0;
  endfunction

  function int pending();
    return level_q.size();
  endfunction

  function void write_reg(logic [srls_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      srls_pkg::REG_SMOOTHING_WEIGHT: regs.smoothing_weight = data;
      srls_pkg::REG_LEVEL_THRESHOLD:  regs.level_threshold  = data[14:0];
      srls_pkg::REG_MAP_INPUT_SPAN:   regs.map_input_span   = data[14:0];
      srls_pkg::REG_OUTPUT_LOW:       regs.output_low       = data[11:0];
      srls_pkg::REG_OUTPUT_HIGH:      regs.output_high      = data[11:0];
      default: ;
    endcase
  endfunction

  // Largest root whose square does not exceed v, built bit by bit from the top.
  function longint root_floor(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v)
        root = trial;
    end
    return root;
  endfunction

  // Accumulate one accepted frame; a closing frame queues the buffer's level.
  function void take_frame(logic signed [15:0] left, logic signed [15:0] right, logic last);
    longint  ls, rs, mean, lvl, w, acc, lo, hi, den, num, q, rad;
    srls_pkg::result_t res;
    if (frames < MAX_FRAMES) begin
      ls = left;
      rs = right;
      square_sum = square_sum + 42'((ls * ls) >> 2) + 42'((rs * rs) >> 2);
      frames++;
    end
    if (!last)
      return;
    mean = longint'(square_sum) / (2 * longint'(frames));
    lvl = root_floor(mean);
    if (lvl > 16384)
      lvl = 16384;
    w = longint'(regs.smoothing_weight);
    acc = longint'(smoothed) * (65536 - w) + lvl * w + 32768;
    acc = acc >> 16;
    if (acc > 16384)
      acc = 16384;
    smoothed = acc[15:0];
    lo = longint'(regs.output_low);
    hi = longint'(regs.output_high);
    if (smoothed > regs.level_threshold) begin
      den = (regs.map_input_span == '0) ? 1 : longint'(regs.map_input_span);
      num = 2 * (hi - lo) * longint'(smoothed) + den;
      q = num / (2 * den);
      // round toward minus infinity on a descending map
      if (num < 0 && (num % (2 * den)) != 0)
        q = q - 1;
      rad = lo + q;
    end else begin
      rad = lo;
    end
    if (rad < 0)
      rad = 0;
    if (rad > 4095)
      rad = 4095;
    res.rms_level = lvl[14:0];
    res.smoothed_level = smoothed[14:0];
    res.radius = rad[11:0];
    level_q.push_back(res);
    square_sum = '0;
    frames = 0;
  endfunction

  function void check_result(logic [14:0] rms, logic [14:0] sm, logic [11:0] rad);
    srls_pkg::result_t exp_res;
    if (level_q.size() == 0) begin
      $error("result with no buffer pending: rms_level %0d", rms);
      errors++;
      return;
    end
    exp_res = level_q.pop_front();
    if (rms !== exp_res.rms_level) begin
      $error("rms_level: expected %0d, actual %0d", exp_res.rms_level, rms);
      errors++;
    end
    if (sm !== exp_res.smoothed_level) begin
      $error("smoothed_level: expected %0d, actual %0d", exp_res.smoothed_level, sm);
      errors++;
    end
    if (rad !== exp_res.radius) begin
      $error("radius: expected %0d, actual %0d", exp_res.radius, rad);
      errors++;
    end
  endfunction
endclass

module tb_stereo_rms_level_smoother;
  localparam int FRAME_LIMIT    = 256;
  localparam int QUIET_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int PHASE_FRAMES   = 125;
  localparam logic [srls_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_left_sample = '0;
  logic signed [15:0] in_right_sample = '0;
  logic               in_last_frame = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [14:0]        out_rms_level;
  logic [14:0]        out_smoothed_level;
  logic [11:0]        out_radius;
  logic               cfg_we = 1'b0;
  logic [srls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int phase_frames;

  level_meter_scoreboard #(FRAME_LIMIT) sb;

  stereo_rms_level_smoother #(.MAX_FRAMES(FRAME_LIMIT)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_sample     (in_left_sample),
    .in_right_sample    (in_right_sample),
    .in_last_frame      (in_last_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rms_level      (out_rms_level),
    .out_smoothed_level (out_smoothed_level),
    .out_radius         (out_radius),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_rms_level, out_smoothed_level, out_radius);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stereo_rms_level_smoother test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_left_sample <= left;
    in_right_sample <= right;
    in_last_frame <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.take_frame(left, right, last);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued level has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [srls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Upper data bits above a register's width are junk and must be masked.
  task automatic program_meter(input logic [15:0] weight, input logic [14:0] thresh,
                               input logic [14:0] span, input logic [11:0] lo,
                               input logic [11:0] hi);
    write_reg(srls_pkg::REG_SMOOTHING_WEIGHT, weight);
    write_reg(srls_pkg::REG_LEVEL_THRESHOLD, {1'($urandom), thresh});
    write_reg(srls_pkg::REG_MAP_INPUT_SPAN, {1'($urandom), span});
    write_reg(srls_pkg::REG_OUTPUT_LOW, {4'($urandom), lo});
    write_reg(srls_pkg::REG_OUTPUT_HIGH, {4'($urandom), hi});
    write_reg(REG_UNUSED_FIRST + 3'($urandom_range(2)), 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample(int loudness);
    logic signed [15:0] s;
    case (loudness)
      0: s = 16'($urandom_range(128)) - 16'd64;
      1: s = 16'($urandom_range(4096)) - 16'd2048;
      2: s = 16'($urandom);
      default: begin
        case ($urandom_range(3))
          0: s = 16'sh8000;
          1: s = 16'sh7fff;
          2: s = 16'sh0000;
          default: s = 16'shffff;
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic send_buffer(input int len);
    int loudness;
    loudness = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      send_frame(pick_sample(loudness), pick_sample(loudness), i == len - 1);
      phase_frames++;
    end
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll == 0)
      return $urandom_range(300, FRAME_LIMIT + 1);
    if (roll < 18)
      return 1;
    return $urandom_range(12, 2);
  endfunction

  initial begin
    int buffers;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, odd samples that square to nothing, bit patterns
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh7fff, 16'sh7fff, 1'b1);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    send_frame(16'sh0001, 16'shffff, 1'b0);
    send_frame(16'shffff, 16'sh0001, 1'b0);
    send_frame(16'sh0001, 16'sh0001, 1'b1);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_frame(16'sh5555, 16'shaaaa, 1'b0);
    send_frame(16'shaaaa, 16'sh5555, 1'b0);
    send_frame(16'sh5555, 16'sh5555, 1'b0);
    send_frame(16'shaaaa, 16'shaaaa, 1'b1);
    send_frame(16'sh0003, 16'shfffd, 1'b1);
    send_frame(16'sh4000, 16'shc000, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        case (phase)
          1: program_meter(16'hffff, 15'd0, 15'd1, 12'd0, 12'd4095);
          2: program_meter(16'h0000, 15'd32767, 15'd32767, 12'd4095, 12'd0);
          3: program_meter(16'd40000, 15'd100, 15'd5000, 12'd3000, 12'd100);
          4: program_meter(16'd30000, 15'd0, 15'd0, 12'd10, 12'd12);
          7: program_meter(srls_pkg::RST_SMOOTHING_WEIGHT, srls_pkg::RST_LEVEL_THRESHOLD,
                           srls_pkg::RST_MAP_INPUT_SPAN, srls_pkg::RST_OUTPUT_LOW,
                           srls_pkg::RST_OUTPUT_HIGH);
          default: program_meter(16'($urandom), 15'($urandom_range(6000)),
                                 15'($urandom_range(20000)), 12'($urandom),
                                 12'($urandom));
        endcase
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      phase_frames = 0;
      buffers = 0;
      // overrun the frame limit once for certain
      if (phase == 3)
        send_buffer(FRAME_LIMIT + 4);
      while (phase_frames < PHASE_FRAMES) begin
        send_buffer(pick_length());
        buffers++;
        if (buffers == 3)
          wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("stereo_rms_level_smoother test passed");
    else
      $display("stereo_rms_level_smoother test failed");
    $finish;
  end
endmodule
